// ----- src/bitmap_block_allocator_core_macros.svh -----
// Assertion macros for the bitmap block allocator.
// Used by the top level; no other dependencies.
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define BBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bba assertion failed");
`define BBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bba assertion failed");
`else
`define BBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/bba_pkg.sv -----
// Shared types and constants for the bitmap block allocator.
// No dependencies.
package bba_pkg;

    localparam int OFFSET_W  = 24;
    localparam int BOFF_W    = 22;
    localparam int BYTES_W   = 23;
    localparam int SIZE_W    = 17;
    localparam int COUNT_W   = 7;
    localparam int DIV_CNT_W = 5;
    localparam int CHUNK_W   = 3;
    localparam int CHUNK     = 1 << CHUNK_W;

    localparam logic CFG_BLK_BYTES   = 1'b0;
    localparam logic CFG_BLOCK_COUNT = 1'b1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 17'd16;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WORK,
        S_UPDATE,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic start;
        logic step;
        logic update;
        logic result;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic div_done;
        logic is_free;
        logic out_busy;
    } t_stat;

endpackage

// ----- src/bitmap_block_allocator_core.sv -----
// Bitmap first-fit block allocator, one request at a time.
// Allocate: the result is set by the bitmap scan of eight blocks per cycle. Free: it is set
// by the restoring divider producing one quotient bit per cycle over the 24-bit offset. The
// next request is accepted in the cycle after the result loads; an output stall delays that.
// Reset (sync, active low): every block free, block size 16, block count 64, no output.
module bitmap_block_allocator_core #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_op,
    input  logic [bba_pkg::OFFSET_W-1:0]  i_free_offset,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_status,
    output logic [bba_pkg::BOFF_W-1:0]    o_block_offset,
    output logic                          o_pool_full,
    output logic                          o_pool_empty,
    output logic [bba_pkg::BYTES_W-1:0]   o_free_bytes,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [bba_pkg::SIZE_W-1:0]    i_cfg_data
);
    import bba_pkg::*;
`include "bitmap_block_allocator_core_macros.svh"

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    bba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    bba_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_op           (i_op),
        .i_free_offset  (i_free_offset),
        .i_cfg_valid    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_block_offset (o_block_offset),
        .o_pool_full    (o_pool_full),
        .o_pool_empty   (o_pool_empty),
        .o_free_bytes   (o_free_bytes)
    );

    `BBA_ASSERT_NXT(a_accept_then_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `BBA_ASSERT_IMP(a_result_slot_free, i_clk, i_rst_n, cmd.result, !(o_valid && i_stall))
    `BBA_ASSERT_NXT(a_result_shows, i_clk, i_rst_n, cmd.result, o_valid)
    `BBA_ASSERT_NXT(a_update_then_hold, i_clk, i_rst_n, cmd.update, o_stall && !cmd.step)

endmodule

// ----- src/bba_div.sv -----
// Restoring divider, one quotient bit per cycle, for offset to block index.
// Depends on bba_pkg.
module bba_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [bba_pkg::OFFSET_W-1:0]  i_dividend,
    input  logic [bba_pkg::SIZE_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [bba_pkg::OFFSET_W-1:0]  o_quotient
);
    import bba_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SIZE_W-1:0]    r_rem;
    logic [SIZE_W-1:0]    r_div;
    logic [OFFSET_W-1:0]  r_quo;
    logic [SIZE_W:0]      trial;
    logic [SIZE_W+1:0]    diff;
    logic [SIZE_W-1:0]    n_rem;
    logic                 n_bit;

    always_comb begin
        trial = {r_rem, r_quo[OFFSET_W-1]};
        diff  = {1'b0, trial} - {2'b00, r_div};
        n_bit = !diff[SIZE_W+1];
        n_rem = n_bit ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == DIV_CNT_W'(OFFSET_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[OFFSET_W-2:0], n_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- src/bba_ctrl.sv -----
// Controller state machine for the bitmap block allocator.
// Depends on bba_pkg; drives commands to bba_dp.
module bba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  bba_pkg::t_stat i_stat,
    output bba_pkg::t_cmd  o_cmd
);
    import bba_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_WORK;
                end
            end
            S_WORK: begin
                o_cmd.step = 1'b1;
                if (i_stat.scan_done && (!i_stat.is_free || i_stat.div_done)) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_RESULT;
            end
            S_RESULT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.result = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/bba_dp.sv -----
// Datapath: free bitmap, chunked scan, divider, result registers, config.
// Depends on bba_pkg and bba_div; steered by bba_ctrl.
module bba_dp #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bba_pkg::t_cmd                 i_cmd,
    output bba_pkg::t_stat                o_stat,
    input  logic                          i_op,
    input  logic [bba_pkg::OFFSET_W-1:0]  i_free_offset,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_index,
    input  logic [bba_pkg::SIZE_W-1:0]    i_cfg_data,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic                          o_status,
    output logic [bba_pkg::BOFF_W-1:0]    o_block_offset,
    output logic                          o_pool_full,
    output logic                          o_pool_empty,
    output logic [bba_pkg::BYTES_W-1:0]   o_free_bytes
);
    import bba_pkg::*;

    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int NCHUNK = (MAX_BLOCKS + CHUNK - 1) / CHUNK;
    localparam int PAD_W  = NCHUNK * CHUNK;
    localparam int CH_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int SIDX_W = CH_W + CHUNK_W;
    localparam int POP_W  = $clog2(MAX_BLOCKS + 1);

    logic [MAX_BLOCKS-1:0] r_bitmap;
    logic [SIZE_W-1:0]     r_blk_bytes;
    logic [COUNT_W-1:0]    r_block_count;
    logic                  r_op;
    logic                  r_scan_done;
    logic [CH_W-1:0]       r_chunk;
    logic [POP_W-1:0]      r_pop;
    logic                  r_found;
    logic [SIDX_W-1:0]     r_idx;
    logic                  r_status;
    logic                  r_alloc_ok;
    logic [POP_W-1:0]      r_cnt;
    logic                  r_out_valid;
    logic                  r_out_status;
    logic [BOFF_W-1:0]     r_out_offset;
    logic                  r_out_full;
    logic                  r_out_empty;
    logic [BYTES_W-1:0]    r_out_bytes;

    logic [SIZE_W-1:0]        act_size;
    logic [COUNT_W-1:0]       act_count;
    logic [PAD_W-1:0]         avail_pad;
    logic [CHUNK-1:0]         chunk_bits;
    logic [CHUNK_W:0]         chunk_pop;
    logic                     chunk_hit;
    logic [CHUNK_W-1:0]       chunk_idx;
    logic                     div_done;
    logic [OFFSET_W-1:0]      quotient;
    logic                     free_ok;
    logic [IDX_W-1:0]         free_idx;
    logic [SIDX_W+SIZE_W-1:0] off_prod;
    logic [POP_W+SIZE_W-1:0]  bytes_prod;
    logic                     out_take;

    assign act_size  = (r_blk_bytes == '0) ? SIZE_W'(1) : r_blk_bytes;
    assign act_count = (r_block_count > COUNT_W'(MAX_BLOCKS)) ? COUNT_W'(MAX_BLOCKS)
                                                                : r_block_count;

    always_comb begin
        avail_pad = '0;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            avail_pad[i] = r_bitmap[i] & (COUNT_W'(i) < act_count);
        end
    end

    assign chunk_bits = avail_pad[r_chunk * CHUNK +: CHUNK];

    always_comb begin
        chunk_pop = '0;
        chunk_hit = 1'b0;
        chunk_idx = '0;
        for (int j = 0; j < CHUNK; j++) begin
            chunk_pop = chunk_pop + (CHUNK_W + 1)'(chunk_bits[j]);
            if (chunk_bits[j] && !chunk_hit) begin
                chunk_hit = 1'b1;
                chunk_idx = CHUNK_W'(j);
            end
        end
    end

    bba_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start),
        .i_dividend (i_free_offset),
        .i_divisor  (act_size),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign free_ok  = quotient < OFFSET_W'(act_count);
    assign free_idx = quotient[IDX_W-1:0];

    assign off_prod   = r_idx * act_size;
    assign bytes_prod = r_cnt * act_size;

    assign out_take = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bitmap      <= '1;
            r_blk_bytes   <= SIZE_RESET;
            r_block_count <= COUNT_RESET;
            r_scan_done   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_BLK_BYTES:   r_blk_bytes   <= i_cfg_data;
                    CFG_BLOCK_COUNT: r_block_count <= i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.start) begin
                r_scan_done <= 1'b0;
            end else if (i_cmd.step && !r_scan_done &&
                         (r_chunk == CH_W'(NCHUNK - 1))) begin
                r_scan_done <= 1'b1;
            end
            if (i_cmd.update) begin
                if (r_op == OP_ALLOC) begin
                    if (r_found) begin
                        r_bitmap[r_idx[IDX_W-1:0]] <= 1'b0;
                    end
                end else if (free_ok) begin
                    r_bitmap[free_idx] <= 1'b1;
                end
            end
            if (i_cmd.result) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op    <= i_op;
            r_chunk <= '0;
            r_pop   <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.step && !r_scan_done) begin
            r_pop <= r_pop + POP_W'(chunk_pop);
            if (!r_found && chunk_hit) begin
                r_found <= 1'b1;
                r_idx   <= {r_chunk, chunk_idx};
            end
            if (r_chunk != CH_W'(NCHUNK - 1)) begin
                r_chunk <= r_chunk + 1'b1;
            end
        end
        if (i_cmd.update) begin
            r_alloc_ok <= 1'b0;
            r_status   <= 1'b1;
            r_cnt      <= r_pop;
            if (r_op == OP_ALLOC) begin
                if (r_found) begin
                    r_alloc_ok <= 1'b1;
                    r_status   <= 1'b0;
                    r_cnt      <= r_pop - 1'b1;
                end
            end else if (free_ok) begin
                r_status <= 1'b0;
                r_cnt    <= r_pop + POP_W'(!r_bitmap[free_idx]);
            end
        end
        if (i_cmd.result) begin
            r_out_status <= r_status;
            r_out_offset <= r_alloc_ok ? BOFF_W'(off_prod) : '0;
            r_out_full   <= (r_cnt == '0);
            r_out_empty  <= &r_bitmap;
            r_out_bytes  <= BYTES_W'(bytes_prod);
        end
    end

    always_comb begin
        o_stat.scan_done = r_scan_done;
        o_stat.div_done  = div_done;
        o_stat.is_free   = (r_op == OP_FREE);
        o_stat.out_busy  = r_out_valid && i_stall;
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_block_offset = r_out_offset;
    assign o_pool_full    = r_out_full;
    assign o_pool_empty   = r_out_empty;
    assign o_free_bytes   = r_out_bytes;

endmodule
